// ===== src/ffm_pkg.sv =====
// Package for the frame field mapper: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ffm_pkg;

  localparam int MAX_FRAME_DEF   = 64;
  localparam int TAG_BITS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int INS_DEPTH = 64;
  localparam int INS_AW    = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_W-1:0] FRAME_LEN_RST = 7'd64;
  localparam logic [CFG_W-1:0] OUT_LIMIT_RST = 7'd64;
  localparam logic [CFG_W-1:0] INS_LEN_RST   = 7'd0;

  typedef enum logic [1:0] {
    CMD_LOAD_TPL = 2'd0,
    CMD_LOAD_INS = 2'd1,
    CMD_FRAME    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_EXTRACT = 2'd0,
    MODE_INSERT  = 2'd1,
    MODE_DELETE  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_FIELD_SEL = 3'd1,
    CFG_FRAME_LEN = 3'd2,
    CFG_OUT_LIMIT = 3'd3,
    CFG_INS_LEN   = 3'd4
  } cfg_idx_e;

  // One word handed from the front end to the back end.
  typedef struct packed {
    logic       is_frame;
    logic       last;
    logic       match;
    logic [5:0] slot;
    logic [7:0] data;
  } ffm_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } ffm_qstat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       has_byte;
    logic       frame_end;
    logic [6:0] byte_count;
  } ffm_res_t;

endpackage

`default_nettype wire

// ===== src/ffm_fifo.sv =====
// Short word queue between the front end and the back end.
// Depends on ffm_pkg for the entry and status types.
`default_nettype none

module ffm_fifo import ffm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  ffm_entry_t      entry_i,
  input  wire logic       pop_i,
  output ffm_entry_t      entry_o,
  output ffm_qstat_t      stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ffm_entry_t        mem_q [DEPTH];
  logic [AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]       cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign entry_o      = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == (AW+1)'(DEPTH));

endmodule

`default_nettype wire

// ===== src/ffm_front.sv =====
// Front end: accepts words, holds the frame template, tracks the frame position
// and classifies each frame byte as matching or not. Depends on ffm_pkg.
`default_nettype none

module ffm_front import ffm_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       in_cmd_i,
  input  wire logic [5:0]       in_slot_i,
  input  wire logic [3:0]       in_tag_i,
  input  wire logic [7:0]       in_byte_i,
  input  wire logic [3:0]       field_select_i,
  input  wire logic [CFG_W-1:0] frame_length_i,
  input  ffm_qstat_t            q_stat_i,
  output logic                  q_push_o,
  output ffm_entry_t            q_entry_o
);

  localparam int PW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CW = ($clog2(MAX_FRAME + 1) > CFG_W) ? $clog2(MAX_FRAME + 1) : CFG_W;

  logic [TAG_BITS-1:0] tpl_mem [MAX_FRAME];
  logic [TAG_BITS-1:0] tpl_rd_q;
  logic [TAG_BITS+3:0] tag_ext, fs_ext;
  logic [TAG_BITS-1:0] tag_w, fs_w;

  logic [PW-1:0] pos_q, pos_d;
  logic          s1_v_q, s1_v_d;
  ffm_entry_t    s1_q;

  logic          accept, is_frame, is_ins, tpl_we, last;
  logic [CW-1:0] fl_ext, len_eff;

  assign tag_ext = {{TAG_BITS{1'b0}}, in_tag_i};
  assign fs_ext  = {{TAG_BITS{1'b0}}, field_select_i};
  assign tag_w   = tag_ext[TAG_BITS-1:0];
  assign fs_w    = fs_ext[TAG_BITS-1:0];

  assign accept   = in_valid_i && in_ready_o;
  assign is_frame = (in_cmd_i == CMD_FRAME);
  assign is_ins   = (in_cmd_i == CMD_LOAD_INS);
  assign tpl_we   = accept && (in_cmd_i == CMD_LOAD_TPL) && (32'(in_slot_i) < MAX_FRAME);

  always_comb begin
    fl_ext = CW'(frame_length_i);
    if (fl_ext == '0) begin
      len_eff = CW'(1);
    end else if (fl_ext > CW'(MAX_FRAME)) begin
      len_eff = CW'(MAX_FRAME);
    end else begin
      len_eff = fl_ext;
    end
    last = (CW'(pos_q) + CW'(1)) >= len_eff;
  end

  assign q_push_o   = s1_v_q && !q_stat_i.full;
  assign in_ready_o = !s1_v_q || !q_stat_i.full;

  always_comb begin
    pos_d  = pos_q;
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = is_frame || is_ins;
      if (is_frame) begin
        pos_d = last ? '0 : pos_q + PW'(1);
      end
    end else if (q_push_o) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tpl_we) begin
      tpl_mem[PW'(in_slot_i)] <= tag_w;
    end
    if (accept) begin
      tpl_rd_q      <= tpl_mem[pos_q];
      s1_q.is_frame <= is_frame;
      s1_q.last     <= is_frame && last;
      s1_q.match    <= 1'b0;
      s1_q.slot     <= in_slot_i;
      s1_q.data     <= in_byte_i;
    end
  end

  always_comb begin
    q_entry_o       = s1_q;
    q_entry_o.match = (tpl_rd_q == fs_w);
  end

endmodule

`default_nettype wire

// ===== src/ffm_back.sv =====
// Back end: holds the insert buffer and the per-frame byte count, applies the
// extract, insert or delete rule and registers each result. Depends on ffm_pkg.
`default_nettype none

module ffm_back import ffm_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  ffm_qstat_t            q_stat_i,
  input  ffm_entry_t            q_entry_i,
  output logic                  q_pop_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [CFG_W-1:0] output_limit_i,
  input  wire logic [CFG_W-1:0] insert_length_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ffm_res_t              out_res_o
);

  localparam int CW = ($clog2(MAX_FRAME + 1) > CFG_W) ? $clog2(MAX_FRAME + 1) : CFG_W;

  logic [7:0]    ibuf_mem [INS_DEPTH];
  logic [7:0]    pf_q;
  logic [CW-1:0] mc_q, mc_d, mc_inc;
  logic          out_v_q, out_v_d;
  ffm_res_t      out_q, res;

  logic            has, bump, prod, out_free, ins_we;
  logic [7:0]      bout;
  logic [CFG_W-1:0] ilen;

  assign ilen     = (insert_length_i > CFG_W'(INS_DEPTH)) ? CFG_W'(INS_DEPTH) : insert_length_i;
  assign out_free = !out_v_q || out_ready_i;
  assign mc_inc   = mc_q + CW'(1);

  always_comb begin
    has  = 1'b0;
    bump = 1'b0;
    bout = q_entry_i.data;
    unique case (mode_i)
      MODE_INSERT: begin
        has = 1'b1;
        if (q_entry_i.match && (mc_q < CW'(ilen))) begin
          bout = pf_q;
          bump = 1'b1;
        end
      end
      MODE_DELETE: begin
        has  = !q_entry_i.match;
        bump = !q_entry_i.match;
      end
      default: begin
        has  = q_entry_i.match && (mc_q < CW'(output_limit_i));
        bump = has;
      end
    endcase
  end

  assign prod    = q_entry_i.is_frame && (has || q_entry_i.last);
  assign q_pop_o = q_stat_i.valid && (!prod || out_free);
  assign ins_we  = q_pop_o && !q_entry_i.is_frame;

  always_comb begin
    res.byte_out   = has ? bout : 8'd0;
    res.has_byte   = has;
    res.frame_end  = q_entry_i.last;
    res.byte_count = bump ? mc_inc[CFG_W-1:0] : mc_q[CFG_W-1:0];
  end

  always_comb begin
    mc_d = mc_q;
    if (q_pop_o && q_entry_i.is_frame) begin
      if (q_entry_i.last) begin
        mc_d = '0;
      end else if (bump) begin
        mc_d = mc_inc;
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (q_pop_o && prod) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      mc_q    <= mc_d;
      out_v_q <= out_v_d;
    end
  end

  // The insert byte for the next count is fetched ahead, with a bypass for a
  // load to the same slot in the same cycle.
  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      ibuf_mem[q_entry_i.slot] <= q_entry_i.data;
    end
    if (ins_we && (q_entry_i.slot == mc_d[INS_AW-1:0])) begin
      pf_q <= q_entry_i.data;
    end else begin
      pf_q <= ibuf_mem[mc_d[INS_AW-1:0]];
    end
    if (q_pop_o && prod) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

// ===== src/frame_field_mapper.sv =====
// Frame field mapper top level: configuration registers, front end, queue, back end.
// A frame byte passes the front-end stage register, the queue and the output register before its result is valid.
// Throughput: one word per cycle while the queue is not full; each stage advances on its own handshake.
// Reset: asynchronous, active low; clears position, byte count, queue and valids.
// Template and insert buffer contents are undefined until loaded.
// Depends on ffm_pkg, ffm_front, ffm_fifo and ffm_back.
`default_nettype none

module frame_field_mapper import ffm_pkg::*; #(
  parameter int MAX_FRAME   = MAX_FRAME_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // slot[5:0], tag[9:6], byte_in[17:10]
  input  wire logic [1:0]           s_axis_tuser,  // command[1:0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // byte_out[7:0], byte_count[14:8]
  output logic                      m_axis_tuser,  // has_byte
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  logic [1:0]       mode_q, mode_d;
  logic [3:0]       fsel_q, fsel_d;
  logic [CFG_W-1:0] flen_q, flen_d, olim_q, olim_d, ilen_q, ilen_d;

  ffm_qstat_t q_stat;
  ffm_entry_t push_entry, head_entry;
  logic       q_push, q_pop;
  ffm_res_t   res;

  always_comb begin
    mode_d = mode_q;
    fsel_d = fsel_q;
    flen_d = flen_q;
    olim_d = olim_q;
    ilen_d = ilen_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:      mode_d = cfg_data_i[1:0];
        CFG_FIELD_SEL: fsel_d = cfg_data_i[3:0];
        CFG_FRAME_LEN: flen_d = cfg_data_i;
        CFG_OUT_LIMIT: olim_d = cfg_data_i;
        CFG_INS_LEN:   ilen_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EXTRACT;
      fsel_q <= '0;
      flen_q <= FRAME_LEN_RST;
      olim_q <= OUT_LIMIT_RST;
      ilen_q <= INS_LEN_RST;
    end else begin
      mode_q <= mode_d;
      fsel_q <= fsel_d;
      flen_q <= flen_d;
      olim_q <= olim_d;
      ilen_q <= ilen_d;
    end
  end

  ffm_front #(
    .MAX_FRAME(MAX_FRAME),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .in_slot_i     (s_axis_tdata[5:0]),
    .in_tag_i      (s_axis_tdata[9:6]),
    .in_byte_i     (s_axis_tdata[17:10]),
    .field_select_i(fsel_q),
    .frame_length_i(flen_q),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  ffm_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .pop_i  (q_pop),
    .entry_o(head_entry),
    .stat_o (q_stat)
  );

  ffm_back #(
    .MAX_FRAME(MAX_FRAME)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .mode_i         (mode_q),
    .output_limit_i (olim_q),
    .insert_length_i(ilen_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_res_o      (res)
  );

  assign m_axis_tdata = {1'b0, res.byte_count, res.byte_out};
  assign m_axis_tuser = res.has_byte;
  assign m_axis_tlast = res.frame_end;

`ifndef SYNTHESIS
  a_empty_result_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("result without a byte is not a frame end");

  a_empty_result_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("result without a byte carries nonzero data");
`endif

endmodule

`default_nettype wire
